### hw/rtl/gfas_pkg.sv
// shared types, constants and helper functions of the gray frame ascii sampler
`timescale 1ns / 1ps
`default_nettype none

package gfas_pkg;

    // frame store geometry
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int FRAME_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    // widths of the item fields and registers
    localparam int FUNC_W    = 1;
    localparam int COORD_W   = 10;
    localparam int CHAN_W    = 8;
    localparam int GRAY_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int LEVEL_W   = 4;
    localparam int CFG_DIM_W = 9;
    localparam int RATIO_W   = 24;
    localparam int SUM_W     = CHAN_W + 2;

    // derived widths
    localparam int DIM_W  = $clog2(((MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                    MAX_SRC_WIDTH : MAX_SRC_HEIGHT) + 1);
    localparam int X_W    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
    localparam int Y_W    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int BASE_W = Y_W + DIM_W;
    localparam int CMP_W  = (DIM_W > COORD_W) ? DIM_W : COORD_W;
    localparam int PROD_W = COORD_W + RATIO_W;
    localparam int FRAC_W = 16;
    localparam int MAP_W  = PROD_W + 1 - FRAC_W;
    localparam int MCMP_W = (MAP_W > DIM_W) ? MAP_W : DIM_W;
    localparam int CFG_CW = (CFG_DIM_W > DIM_W) ? CFG_DIM_W : DIM_W;

    // q8.16 round half up
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1 << (FRAC_W - 1));

    // divide by three as multiply by reciprocal, exact for sums up to 765
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_W     = SUM_W + DIV3_SHIFT - 1;

    // request decoupling queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // result buffer in the back part
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

    // register indexes
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_X_RATIO    = 2'd2;
    localparam logic [1:0] REG_Y_RATIO    = 2'd3;

    localparam logic [CFG_DIM_W-1:0] SRC_WIDTH_RST  = 9'd256;
    localparam logic [CFG_DIM_W-1:0] SRC_HEIGHT_RST = 9'd256;
    localparam logic [RATIO_W-1:0]   RATIO_RST      = 24'd65536;

    // brightness ramp
    localparam int RAMP_TOP = 12;
    localparam logic [GRAY_W-1:0] LEVEL_THR [1:RAMP_TOP] = '{
        8'd11, 8'd32, 8'd54, 8'd75, 8'd96, 8'd117,
        8'd139, 8'd160, 8'd181, 8'd202, 8'd224, 8'd245
    };
    localparam logic [CHAR_W-1:0] RAMP_CHARS [0:RAMP_TOP] = '{
        7'd32, 7'd46, 7'd44, 7'd45, 7'd126, 7'd58, 7'd59,
        7'd61, 7'd33, 7'd42, 7'd35, 7'd36, 7'd64
    };

    typedef struct packed {
        logic [DIM_W-1:0]   w_eff;
        logic [DIM_W-1:0]   h_eff;
        logic [RATIO_W-1:0] x_ratio;
        logic [RATIO_W-1:0] y_ratio;
    } cfg_t;

    typedef struct packed {
        logic              is_sample;
        logic [ADDR_W-1:0] addr;
        logic [GRAY_W-1:0] gray;
    } req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [CHAR_W-1:0]  char_code;
    } res_t;

    // round 12*gray/255 to nearest by threshold compares
    function automatic logic [LEVEL_W-1:0] level_of(input logic [GRAY_W-1:0] gray);
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        for (int k = 1; k <= RAMP_TOP; k++) begin
            if (gray >= LEVEL_THR[k]) begin
                lvl = LEVEL_W'(k);
            end
        end
        return lvl;
    endfunction

    function automatic logic [CHAR_W-1:0] ramp_char(input logic [LEVEL_W-1:0] lvl);
        logic [CHAR_W-1:0] c;
        c = RAMP_CHARS[RAMP_TOP];
        for (int k = 0; k <= RAMP_TOP; k++) begin
            if (lvl == LEVEL_W'(k)) begin
                c = RAMP_CHARS[k];
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gfas_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module gfas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/gfas_front.sv
// front pipeline: accepts items, maps coordinates and forms frame store requests
`timescale 1ns / 1ps
`default_nettype none

module gfas_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gfas_pkg::cfg_t               cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [gfas_pkg::FUNC_W-1:0]  in_func,
    input  wire logic [gfas_pkg::COORD_W-1:0] in_col,
    input  wire logic [gfas_pkg::COORD_W-1:0] in_row,
    input  wire logic [gfas_pkg::CHAN_W-1:0]  in_red,
    input  wire logic [gfas_pkg::CHAN_W-1:0]  in_green,
    input  wire logic [gfas_pkg::CHAN_W-1:0]  in_blue,
    input  wire logic                         q_full,
    output logic                              q_push,
    output gfas_pkg::req_t                    q_entry
);

    // stage 1: captured item
    logic                           s1_valid_reg;
    logic                           s1_sample_reg;
    logic [gfas_pkg::COORD_W-1:0]   s1_col_reg;
    logic [gfas_pkg::COORD_W-1:0]   s1_row_reg;
    logic [gfas_pkg::SUM_W-1:0]     s1_sum_reg;

    // stage 2: products, gray, range check
    logic                           s2_valid_reg;
    logic                           s2_sample_reg;
    logic                           s2_inrange_reg;
    logic [gfas_pkg::X_W-1:0]       s2_col_reg;
    logic [gfas_pkg::Y_W-1:0]       s2_row_reg;
    logic [gfas_pkg::PROD_W-1:0]    s2_prod_x_reg;
    logic [gfas_pkg::PROD_W-1:0]    s2_prod_y_reg;
    logic [gfas_pkg::GRAY_W-1:0]    s2_gray_reg;

    // stage 3: source coordinates
    logic                           s3_valid_reg;
    logic                           s3_sample_reg;
    logic                           s3_keep_reg;
    logic [gfas_pkg::X_W-1:0]       s3_sx_reg;
    logic [gfas_pkg::Y_W-1:0]       s3_sy_reg;
    logic [gfas_pkg::GRAY_W-1:0]    s3_gray_reg;

    // stage 4: row base
    logic                           s4_valid_reg;
    logic                           s4_sample_reg;
    logic                           s4_keep_reg;
    logic [gfas_pkg::X_W-1:0]       s4_sx_reg;
    logic [gfas_pkg::BASE_W-1:0]    s4_base_reg;
    logic [gfas_pkg::GRAY_W-1:0]    s4_gray_reg;

    logic                           adv;
    logic [gfas_pkg::SUM_W-1:0]     sum_next;
    logic [gfas_pkg::DIV3_W-1:0]    div3_prod;
    logic                           inrange_next;
    logic [gfas_pkg::MAP_W-1:0]     map_x;
    logic [gfas_pkg::MAP_W-1:0]     map_y;
    logic [gfas_pkg::DIM_W-1:0]     w_last;
    logic [gfas_pkg::DIM_W-1:0]     h_last;
    logic [gfas_pkg::X_W-1:0]       sx_next;
    logic [gfas_pkg::Y_W-1:0]       sy_next;

    // whole pipeline holds only when a kept request meets a full queue
    assign adv      = !(s4_valid_reg && s4_keep_reg && q_full);
    assign in_ready = adv;

    assign sum_next = gfas_pkg::SUM_W'(in_red) + gfas_pkg::SUM_W'(in_green)
                    + gfas_pkg::SUM_W'(in_blue);

    assign div3_prod = gfas_pkg::DIV3_W'(s1_sum_reg)
                     * gfas_pkg::DIV3_W'(gfas_pkg::DIV3_MUL);

    assign inrange_next =
        (gfas_pkg::CMP_W'(s1_col_reg) < gfas_pkg::CMP_W'(cfg.w_eff)) &&
        (gfas_pkg::CMP_W'(s1_row_reg) < gfas_pkg::CMP_W'(cfg.h_eff));

    assign map_x  = gfas_pkg::MAP_W'(((gfas_pkg::PROD_W + 1)'(s2_prod_x_reg)
                    + gfas_pkg::ROUND_HALF) >> gfas_pkg::FRAC_W);
    assign map_y  = gfas_pkg::MAP_W'(((gfas_pkg::PROD_W + 1)'(s2_prod_y_reg)
                    + gfas_pkg::ROUND_HALF) >> gfas_pkg::FRAC_W);
    assign w_last = cfg.w_eff - gfas_pkg::DIM_W'(1);
    assign h_last = cfg.h_eff - gfas_pkg::DIM_W'(1);

    always_comb
    begin
        if (!s2_sample_reg) begin
            sx_next = s2_col_reg;
            sy_next = s2_row_reg;
        end else begin
            if (gfas_pkg::MCMP_W'(map_x) > gfas_pkg::MCMP_W'(w_last)) begin
                sx_next = gfas_pkg::X_W'(w_last);
            end else begin
                sx_next = gfas_pkg::X_W'(map_x);
            end
            if (gfas_pkg::MCMP_W'(map_y) > gfas_pkg::MCMP_W'(h_last)) begin
                sy_next = gfas_pkg::Y_W'(h_last);
            end else begin
                sy_next = gfas_pkg::Y_W'(map_y);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_sample_reg  <= (in_func == gfas_pkg::FUNC_SAMPLE);
            s1_col_reg     <= in_col;
            s1_row_reg     <= in_row;
            s1_sum_reg     <= sum_next;

            s2_sample_reg  <= s1_sample_reg;
            s2_inrange_reg <= inrange_next;
            s2_col_reg     <= gfas_pkg::X_W'(s1_col_reg);
            s2_row_reg     <= gfas_pkg::Y_W'(s1_row_reg);
            s2_prod_x_reg  <= gfas_pkg::PROD_W'(s1_col_reg)
                            * gfas_pkg::PROD_W'(cfg.x_ratio);
            s2_prod_y_reg  <= gfas_pkg::PROD_W'(s1_row_reg)
                            * gfas_pkg::PROD_W'(cfg.y_ratio);
            s2_gray_reg    <= div3_prod[gfas_pkg::DIV3_SHIFT +: gfas_pkg::GRAY_W];

            s3_sample_reg  <= s2_sample_reg;
            s3_keep_reg    <= s2_sample_reg || s2_inrange_reg;
            s3_sx_reg      <= sx_next;
            s3_sy_reg      <= sy_next;
            s3_gray_reg    <= s2_gray_reg;

            s4_sample_reg  <= s3_sample_reg;
            s4_keep_reg    <= s3_keep_reg;
            s4_sx_reg      <= s3_sx_reg;
            s4_base_reg    <= gfas_pkg::BASE_W'(s3_sy_reg) * gfas_pkg::BASE_W'(cfg.w_eff);
            s4_gray_reg    <= s3_gray_reg;
        end
    end

    // loads outside the image are dropped here
    assign q_push            = s4_valid_reg && s4_keep_reg && adv;
    assign q_entry.is_sample = s4_sample_reg;
    assign q_entry.addr      = gfas_pkg::ADDR_W'(s4_base_reg + gfas_pkg::BASE_W'(s4_sx_reg));
    assign q_entry.gray      = s4_gray_reg;

endmodule

`default_nettype wire

### hw/rtl/gfas_queue.sv
// short request queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module gfas_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gfas_pkg::req_t push_entry,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output gfas_pkg::req_t      head_entry
);

    gfas_pkg::req_t                 slot_reg [0:gfas_pkg::Q_DEPTH-1];
    logic [gfas_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [gfas_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [gfas_pkg::Q_CNT_W-1:0]   cnt_reg;
    logic [gfas_pkg::Q_CNT_W-1:0]   cnt_next;

    assign full       = (cnt_reg == gfas_pkg::Q_CNT_W'(gfas_pkg::Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + gfas_pkg::Q_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - gfas_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + gfas_pkg::Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + gfas_pkg::Q_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gfas_back.sv
// back part: frame store access, level lookup and result buffer
`timescale 1ns / 1ps
`default_nettype none

module gfas_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire gfas_pkg::req_t head_entry,
    output logic                pop,
    output logic                res_valid,
    input  wire logic           res_ready,
    output gfas_pkg::res_t      res_data
);

    logic                             rd_valid_reg;
    logic [gfas_pkg::GRAY_W-1:0]      rdata;
    logic                             room;
    logic                             ram_we;
    gfas_pkg::res_t                   res_next;
    gfas_pkg::res_t                   buf_reg [0:gfas_pkg::OUT_DEPTH-1];
    logic [gfas_pkg::OUT_PTR_W-1:0]   buf_wr_reg;
    logic [gfas_pkg::OUT_PTR_W-1:0]   buf_rd_reg;
    logic [gfas_pkg::OUT_CNT_W-1:0]   buf_cnt_reg;
    logic [gfas_pkg::OUT_CNT_W-1:0]   buf_cnt_next;
    logic                             buf_push;
    logic                             buf_pop;

    // a read goes out only if its result has a buffer slot waiting
    assign room   = (buf_cnt_reg + gfas_pkg::OUT_CNT_W'(rd_valid_reg))
                  < gfas_pkg::OUT_CNT_W'(gfas_pkg::OUT_DEPTH);
    assign pop    = head_valid && (!head_entry.is_sample || room);
    assign ram_we = !head_entry.is_sample;

    gfas_ram #(
        .WIDTH (gfas_pkg::GRAY_W),
        .DEPTH (gfas_pkg::FRAME_DEPTH)
    ) u_frame (
        .clk   (clk),
        .en    (pop),
        .we    (ram_we),
        .addr  (head_entry.addr),
        .wdata (head_entry.gray),
        .rdata (rdata)
    );

    always_comb
    begin
        res_next.level     = gfas_pkg::level_of(rdata);
        res_next.char_code = gfas_pkg::ramp_char(res_next.level);
    end

    assign buf_push  = rd_valid_reg;
    assign buf_pop   = res_valid && res_ready;
    assign res_valid = (buf_cnt_reg != '0);
    assign res_data  = buf_reg[buf_rd_reg];

    always_comb
    begin
        buf_cnt_next = buf_cnt_reg;
        if (buf_push && !buf_pop) begin
            buf_cnt_next = buf_cnt_reg + gfas_pkg::OUT_CNT_W'(1);
        end else if (buf_pop && !buf_push) begin
            buf_cnt_next = buf_cnt_reg - gfas_pkg::OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_valid_reg <= 1'b0;
            buf_wr_reg   <= '0;
            buf_rd_reg   <= '0;
            buf_cnt_reg  <= '0;
        end else begin
            rd_valid_reg <= pop && head_entry.is_sample;
            if (buf_push) begin
                buf_wr_reg <= buf_wr_reg + gfas_pkg::OUT_PTR_W'(1);
            end
            if (buf_pop) begin
                buf_rd_reg <= buf_rd_reg + gfas_pkg::OUT_PTR_W'(1);
            end
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_push) begin
            buf_reg[buf_wr_reg] <= res_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gray_frame_ascii_sampler.sv
// top level of the gray frame ascii sampler: config registers, front, queue, back
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  s_tdata: col, row, red, green, blue; s_tuser: func
// m_*       out        m_tvalid / m_tready  m_tdata: char_code, level
// apb       in         psel, penable, pwrite (pready always high)  four config registers
//
// one request per cycle sustained while results are taken; the four-stage front pipeline
// (capture, multiply, round and clamp, row base multiply) feeds a four-entry queue, and
// the back part does one frame store access per cycle while samples find result buffer room;
// reset clears control state only; the frame store needs no clearing pass and an
// entry reads as garbage until it is loaded
// a stalled result output fills the back buffer, then the queue, then the front stops
// taking requests; loads at the queue head keep flowing while the result buffer is
// full, up to the first waiting sample
`timescale 1ns / 1ps
`default_nettype none

module gray_frame_ascii_sampler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // col[9:0], row[19:10], red[27:20],
                                        // green[35:28], blue[43:36], zero pad
    input  wire logic [0:0]  s_tuser,   // func[0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // char_code[6:0], level[10:7], zero pad
);

    // config registers
    logic [gfas_pkg::CFG_DIM_W-1:0] src_width_reg;
    logic [gfas_pkg::CFG_DIM_W-1:0] src_height_reg;
    logic [gfas_pkg::RATIO_W-1:0]   x_ratio_reg;
    logic [gfas_pkg::RATIO_W-1:0]   y_ratio_reg;
    logic [1:0]                     reg_index;
    logic                           wr_en;

    gfas_pkg::cfg_t                 cfg;
    logic                           q_push;
    gfas_pkg::req_t                 q_entry;
    logic                           q_full;
    logic                           q_pop;
    logic                           q_head_valid;
    gfas_pkg::req_t                 q_head;
    gfas_pkg::res_t                 res_data;

    // apb: writes land at the access phase, reads are plain muxes
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            src_width_reg  <= gfas_pkg::SRC_WIDTH_RST;
            src_height_reg <= gfas_pkg::SRC_HEIGHT_RST;
            x_ratio_reg    <= gfas_pkg::RATIO_RST;
            y_ratio_reg    <= gfas_pkg::RATIO_RST;
        end else if (wr_en) begin
            case (reg_index)
                gfas_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[gfas_pkg::CFG_DIM_W-1:0];
                gfas_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[gfas_pkg::CFG_DIM_W-1:0];
                gfas_pkg::REG_X_RATIO:    x_ratio_reg    <= pwdata[gfas_pkg::RATIO_W-1:0];
                gfas_pkg::REG_Y_RATIO:    y_ratio_reg    <= pwdata[gfas_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            gfas_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width_reg);
            gfas_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height_reg);
            gfas_pkg::REG_X_RATIO:    prdata = 32'(x_ratio_reg);
            gfas_pkg::REG_Y_RATIO:    prdata = 32'(y_ratio_reg);
            default:                  prdata = '0;
        endcase
    end

    // effective image size: zero counts as one, anything past the store is cut
    always_comb
    begin
        if (src_width_reg == '0) begin
            cfg.w_eff = gfas_pkg::DIM_W'(1);
        end else if (gfas_pkg::CFG_CW'(src_width_reg)
                     > gfas_pkg::CFG_CW'(gfas_pkg::MAX_SRC_WIDTH)) begin
            cfg.w_eff = gfas_pkg::DIM_W'(gfas_pkg::MAX_SRC_WIDTH);
        end else begin
            cfg.w_eff = gfas_pkg::DIM_W'(src_width_reg);
        end
        if (src_height_reg == '0) begin
            cfg.h_eff = gfas_pkg::DIM_W'(1);
        end else if (gfas_pkg::CFG_CW'(src_height_reg)
                     > gfas_pkg::CFG_CW'(gfas_pkg::MAX_SRC_HEIGHT)) begin
            cfg.h_eff = gfas_pkg::DIM_W'(gfas_pkg::MAX_SRC_HEIGHT);
        end else begin
            cfg.h_eff = gfas_pkg::DIM_W'(src_height_reg);
        end
        cfg.x_ratio = x_ratio_reg;
        cfg.y_ratio = y_ratio_reg;
    end

    // front: capture, map coordinates, form store requests
    gfas_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_func  (s_tuser[0]),
        .in_col   (s_tdata[9:0]),
        .in_row   (s_tdata[19:10]),
        .in_red   (s_tdata[27:20]),
        .in_green (s_tdata[35:28]),
        .in_blue  (s_tdata[43:36]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // decoupling queue
    gfas_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    // back: frame store access and result buffer
    gfas_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_data   (res_data)
    );

    assign m_tdata = {5'b0, res_data.level, res_data.char_code};

endmodule

`default_nettype wire

### dv/gray_frame_ascii_sampler_tb.sv
// self-checking testbench of the gray frame ascii sampler against a mirrored frame store
`timescale 1ns / 1ps

module gray_frame_ascii_sampler_tb;
    import gfas_pkg::*;

    // margin that lets trailing loads retire once every owed character is in
    localparam int LATENCY_PAD     = 16;
    // one long receiver hold-off, long enough to back the block up to its input
    localparam int HOLD_OFF_CYCLES = 300;
    // cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT     = 5000;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_code;
        logic [LEVEL_W-1:0] level;
    } char_pick_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // col[9:0], row[19:10], red[27:20], green[35:28], blue[43:36]
    logic [0:0]  s_tuser;   // func[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // char_code[6:0], level[10:7]

    // mirror of the register file and of the frame store
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [RATIO_W-1:0]   x_ratio_reg;
    logic [RATIO_W-1:0]   y_ratio_reg;
    logic [GRAY_W-1:0]    mirror_frame [FRAME_DEPTH];
    bit                   loaded [FRAME_DEPTH];

    // in-image spots loaded under the current geometry, used to aim samples
    int loaded_cols [$];
    int loaded_rows [$];

    // characters still owed by the block, oldest first
    char_pick_t expected_chars [$];

    // brightness ramp, darkest first
    string ramp_text = " .,-~:;=!*#$@";

    bit gaps_on;
    bit hold_results;
    int errors;
    int quiet_cycles;

    gray_frame_ascii_sampler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // mirror arithmetic
    // ------------------------------------------------------------------

    // zero counts as one, anything past the store is cut to the store
    function automatic int eff_dim(input logic [CFG_DIM_W-1:0] v, input int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    // nearest source coordinate in q8.16, half rounds up, clamped to the last pixel
    function automatic int source_coord(input logic [COORD_W-1:0] c,
                                        input logic [RATIO_W-1:0] ratio, input int limit);
        longint unsigned p;
        p = c;
        p = (p * ratio + 64'h8000) >> 16;
        if (p > longint'(limit - 1))
            p = limit - 1;
        return int'(p);
    endfunction

    // flat store index that a sample at output (c, r) reads
    function automatic int sample_index(input logic [COORD_W-1:0] c,
                                        input logic [COORD_W-1:0] r);
        int w;
        int h;
        w = eff_dim(width_reg, MAX_SRC_WIDTH);
        h = eff_dim(height_reg, MAX_SRC_HEIGHT);
        return source_coord(r, y_ratio_reg, h) * w + source_coord(c, x_ratio_reg, w);
    endfunction

    // apply one taken request to the mirror; a sample owes one character
    task automatic mirror_request(input logic [FUNC_W-1:0] f, input logic [COORD_W-1:0] c,
                                  input logic [COORD_W-1:0] r, input logic [CHAN_W-1:0] red,
                                  input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
        int w;
        int h;
        int idx;
        int lvl;
        char_pick_t pick;
        w = eff_dim(width_reg, MAX_SRC_WIDTH);
        h = eff_dim(height_reg, MAX_SRC_HEIGHT);
        if (f == FUNC_LOAD)
        begin
            // loads outside the image leave the store alone
            if (int'(c) < w && int'(r) < h)
            begin
                idx = int'(r) * w + int'(c);
                mirror_frame[idx] = GRAY_W'((int'(red) + int'(green) + int'(blue)) / 3);
                loaded[idx] = 1'b1;
            end
        end
        else
        begin
            idx = sample_index(c, r);
            lvl = (24 * int'(mirror_frame[idx]) + 255) / 510;
            if (lvl > RAMP_TOP)
                lvl = RAMP_TOP;
            pick.level     = LEVEL_W'(lvl);
            pick.char_code = CHAR_W'(ramp_text[lvl]);
            expected_chars.push_back(pick);
        end
    endtask

    // ------------------------------------------------------------------
    // bus drivers
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request and hold it until taken; valid stays up for the next one
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [COORD_W-1:0] c,
                                input logic [COORD_W-1:0] r, input logic [CHAN_W-1:0] red,
                                input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'b0000, blue, green, red, r, c};
        do
            @(posedge clk);
        while (!s_tready);
        mirror_request(f, c, r, red, green, blue);
    endtask

    // in-image load with a random color, remembered as a sample target
    task automatic send_load(input int c, input int r);
        loaded_cols.push_back(c);
        loaded_rows.push_back(r);
        send_request(FUNC_LOAD, COORD_W'(c), COORD_W'(r), CHAN_W'($urandom_range(0, 255)),
                     CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
    endtask

    // sample at a random output spot that lands on a loaded pixel
    task automatic send_sample();
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;
        int  j;
        bit  found;
        found = 1'b0;
        // first blind picks over the whole field range and near the origin
        for (int k = 0; k < 16 && !found; k++)
        begin
            c = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 1023))
                                     : COORD_W'($urandom_range(0, 63));
            r = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 1023))
                                     : COORD_W'($urandom_range(0, 63));
            found = loaded[sample_index(c, r)];
        end
        // sparse store: aim at a loaded spot, exact when the ratio is one
        for (int k = 0; k < 8 && !found && loaded_cols.size() > 0; k++)
        begin
            j = $urandom_range(0, loaded_cols.size() - 1);
            c = COORD_W'(loaded_cols[j]);
            r = COORD_W'(loaded_rows[j]);
            found = loaded[sample_index(c, r)];
        end
        // the origin is loaded first thing and maps to itself under any ratio
        if (!found)
        begin
            c = '0;
            r = '0;
        end
        send_request(FUNC_SAMPLE, c, r, CHAN_W'($urandom_range(0, 255)),
                     CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
    endtask

    // setup then access phase; the caller releases the bus after the last write
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (index)
            REG_SRC_WIDTH:  width_reg   = value[CFG_DIM_W-1:0];
            REG_SRC_HEIGHT: height_reg  = value[CFG_DIM_W-1:0];
            REG_X_RATIO:    x_ratio_reg = value[RATIO_W-1:0];
            REG_Y_RATIO:    y_ratio_reg = value[RATIO_W-1:0];
            default: ;
        endcase
    endtask

    // stop offering, collect every owed character, let trailing loads retire
    task automatic wait_until_quiet();
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    // registers change only with the block empty
    task automatic set_geometry(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                                input logic [RATIO_W-1:0] xr, input logic [RATIO_W-1:0] yr);
        wait_until_quiet();
        write_register(REG_SRC_WIDTH, 32'(w));
        write_register(REG_SRC_HEIGHT, 32'(h));
        write_register(REG_X_RATIO, 32'(xr));
        write_register(REG_Y_RATIO, 32'(yr));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        loaded_cols.delete();
        loaded_rows.delete();
    endtask

    // fill a small image completely, a large one at its corners and scattered spots
    task automatic load_picture();
        int w;
        int h;
        w = eff_dim(width_reg, MAX_SRC_WIDTH);
        h = eff_dim(height_reg, MAX_SRC_HEIGHT);
        if (w * h <= 128)
        begin
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++)
                    send_load(c, r);
        end
        else
        begin
            send_load(0, 0);
            send_load(w - 1, 0);
            send_load(0, h - 1);
            send_load(w - 1, h - 1);
            repeat (40) send_load($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset geometry: 256 x 256 at ratio one, far corners, edge clamping, stray loads
    task automatic test_reset_geometry();
        gaps_on = 1'b0;
        send_request(FUNC_LOAD, 10'd0, 10'd0, 8'd255, 8'd255, 8'd255);
        send_request(FUNC_LOAD, 10'd255, 10'd255, 8'd0, 8'd0, 8'd0);
        send_request(FUNC_LOAD, 10'd255, 10'd0, 8'd255, 8'd255, 8'd254);
        // off the right edge, off the bottom, off both: all dropped
        send_request(FUNC_LOAD, 10'd256, 10'd3, 8'd0, 8'd0, 8'd0);
        send_request(FUNC_LOAD, 10'd3, 10'd256, 8'd0, 8'd0, 8'd0);
        send_request(FUNC_LOAD, 10'd1023, 10'd1023, 8'd17, 8'd0, 8'd0);
        send_request(FUNC_SAMPLE, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0);
        send_request(FUNC_SAMPLE, 10'd255, 10'd255, 8'd0, 8'd0, 8'd0);
        // past the edge on both axes, then on the column only, clamped to the last row and column
        send_request(FUNC_SAMPLE, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255);
        send_request(FUNC_SAMPLE, 10'd1023, 10'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // one pixel at the lowest gray of each level, then every ramp character
    task automatic test_level_ramp();
        int gray;
        set_geometry(9'd13, 9'd1, RATIO_RST, RATIO_RST);
        gaps_on = 1'b0;
        for (int k = 0; k <= RAMP_TOP; k++)
        begin
            gray = (k == 0) ? 0 : (510 * k - 255 + 23) / 24;
            send_request(FUNC_LOAD, COORD_W'(k), 10'd0, CHAN_W'(gray), CHAN_W'(gray),
                         CHAN_W'(gray));
        end
        for (int k = 0; k <= RAMP_TOP; k++)
            send_request(FUNC_SAMPLE, COORD_W'(k), 10'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // load an image, then mostly samples mixed with reloads and dropped loads
    task automatic test_random_traffic(input logic [CFG_DIM_W-1:0] w,
                                       input logic [CFG_DIM_W-1:0] h,
                                       input logic [RATIO_W-1:0] xr,
                                       input logic [RATIO_W-1:0] yr,
                                       input bit gaps, input int count);
        int wv;
        int hv;
        int roll;
        set_geometry(w, h, xr, yr);
        gaps_on = gaps;
        load_picture();
        wv = eff_dim(width_reg, MAX_SRC_WIDTH);
        hv = eff_dim(height_reg, MAX_SRC_HEIGHT);
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
                send_sample();
            else if (roll < 90)
                send_load($urandom_range(0, wv - 1), $urandom_range(0, hv - 1));
            else if ($urandom_range(0, 1))
                send_request(FUNC_LOAD, COORD_W'($urandom_range(wv, 1023)),
                             COORD_W'($urandom_range(0, 1023)), CHAN_W'($urandom_range(0, 255)),
                             CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
            else
                send_request(FUNC_LOAD, COORD_W'($urandom_range(0, 1023)),
                             COORD_W'($urandom_range(hv, 1023)), CHAN_W'($urandom_range(0, 255)),
                             CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
        end
    endtask

    // result side blocked for a long stretch while samples keep coming,
    // then the sender waits for everything before it resumes
    task automatic test_backpressure();
        set_geometry(9'd6, 9'd6, 24'h00C000, 24'h00C000);
        gaps_on = 1'b0;
        load_picture();
        hold_results = 1'b1;
        repeat (48) send_sample();
        wait_until_quiet();
        gaps_on = 1'b1;
        repeat (24) send_sample();
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver: random stalls when gaps are on, one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            else if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = idle_gap();
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    // compare every character taken against the oldest one owed
    always @(posedge clk)
    begin : check_results
        char_pick_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("character %h with no sample waiting", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_tdata[CHAR_W-1:0] !== want.char_code)
                begin
                    $error("char_code expected %0d got %0d", want.char_code,
                           m_tdata[CHAR_W-1:0]);
                    errors++;
                end
                if (m_tdata[CHAR_W+LEVEL_W-1:CHAR_W] !== want.level)
                begin
                    $error("level expected %0d got %0d", want.level,
                           m_tdata[CHAR_W+LEVEL_W-1:CHAR_W]);
                    errors++;
                end
            end
        end
    end

    // hang detector: any request, character or register write resets the count
    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable && pwrite && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[gray_frame_ascii_sampler] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin : run_tests
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_LOAD;
        errors       = 0;
        gaps_on      = 1'b0;
        hold_results = 1'b0;
        width_reg    = SRC_WIDTH_RST;
        height_reg   = SRC_HEIGHT_RST;
        x_ratio_reg  = RATIO_RST;
        y_ratio_reg  = RATIO_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_geometry();
        test_level_ramp();
        // small image at ratio one
        test_random_traffic(9'd8, 9'd6, 24'h010000, 24'h010000, 1'b1, 70);
        // zero size counts as one pixel, zero ratio maps everything to the origin
        test_random_traffic(9'd0, 9'd0, 24'h000000, 24'h000000, 1'b1, 30);
        // oversized registers cut to the store, steepest and flattest ratios
        test_random_traffic(9'd511, 9'd300, 24'hFFFFFF, 24'h000001, 1'b0, 60);
        // fractional ratios, shrink on one axis and stretch on the other, then random ratios
        test_random_traffic(9'd9, 9'd7, 24'h00A000, 24'h018000, 1'b1, 30);
        test_random_traffic(9'd10, 9'd8, RATIO_W'($urandom_range(24'h2000, 24'h30000)),
                            RATIO_W'($urandom_range(24'h2000, 24'h30000)), 1'b1, 80);
        // full store size
        test_random_traffic(9'd256, 9'd256, 24'h010000, 24'h010000, 1'b1, 30);
        // single column and single row images
        test_random_traffic(9'd1, 9'd64, 24'h020000, 24'h008000, 1'b0, 50);
        test_random_traffic(9'd64, 9'd1, 24'h008000, 24'h020000, 1'b1, 50);
        test_backpressure();

        wait_until_quiet();
        if (errors == 0)
            $display("[gray_frame_ascii_sampler] OK");
        else
            $display("[gray_frame_ascii_sampler] ERROR");
        $finish;
    end

endmodule

### gray_frame_ascii_sampler.f
hw/rtl/gfas_pkg.sv
hw/rtl/gfas_ram.sv
hw/rtl/gfas_front.sv
hw/rtl/gfas_queue.sv
hw/rtl/gfas_back.sv
hw/rtl/gray_frame_ascii_sampler.sv
dv/gray_frame_ascii_sampler_tb.sv
